// ===== rtl/ldq_pkg.sv =====
// Package for the linear array deque: operation and status codes,
// payload widths, default capacity and controller/datapath link types.
// No dependencies.
`default_nettype none

package ldq_pkg;

  localparam int unsigned CAPACITY_DEF = 8;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 4;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the incoming item
    logic exec;    // update indices, write store, start refill read
    logic finish;  // fold in read data, load the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/ldq_if.sv =====
// Item channels of the linear array deque: operation requests in, results out.
// Depends on ldq_pkg.
`default_nettype none

interface ldq_in_if;
  logic                              valid;
  logic                              ready;
  logic        [ldq_pkg::MODE_W-1:0] mode;
  logic signed [ldq_pkg::DATA_W-1:0] item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface ldq_out_if;
  logic                                valid;
  logic                                ready;
  logic        [ldq_pkg::STATUS_W-1:0] status;
  logic signed [ldq_pkg::DATA_W-1:0]   removed_value;
  logic signed [ldq_pkg::DATA_W-1:0]   front_value;
  logic signed [ldq_pkg::DATA_W-1:0]   rear_value;
  logic                                is_empty;
  logic        [ldq_pkg::COUNT_W-1:0]  item_count;

  modport source (output valid, output status, output removed_value, output front_value,
                  output rear_value, output is_empty, output item_count, input ready);
  modport sink   (input valid, input status, input removed_value, input front_value,
                  input rear_value, input is_empty, input item_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/ldq_ctrl.sv =====
// Sequencing controller of the linear array deque: accept, execute, finish.
// Depends on ldq_pkg.
`default_nettype none

module ldq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ldq_pkg::dp_status_t dp_status_i,
  output ldq_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.finish  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // wait here while a previous result is still unclaimed
        if (dp_status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ldq_dp.sv =====
// Datapath of the linear array deque: indices, element store, cached end
// values and the result register. Depends on ldq_pkg.
`default_nettype none

module ldq_dp #(
  parameter int unsigned CAPACITY = ldq_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ldq_pkg::ctrl_cmd_t                  cmd_i,
  output ldq_pkg::dp_status_t                      status_o,
  input  wire logic        [ldq_pkg::MODE_W-1:0]   mode_i,
  input  wire logic signed [ldq_pkg::DATA_W-1:0]   item_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic             [ldq_pkg::STATUS_W-1:0] result_status_o,
  output logic signed      [ldq_pkg::DATA_W-1:0]   removed_value_o,
  output logic signed      [ldq_pkg::DATA_W-1:0]   front_value_o,
  output logic signed      [ldq_pkg::DATA_W-1:0]   rear_value_o,
  output logic                                     is_empty_o,
  output logic             [ldq_pkg::COUNT_W-1:0]  item_count_o
);

  localparam int unsigned IW = $clog2(CAPACITY + 1);           // index 0..CAPACITY
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = (IW > ldq_pkg::COUNT_W) ? IW : ldq_pkg::COUNT_W;
  localparam logic [IW-1:0] CAP_IDX = IW'(CAPACITY);
  localparam logic [IW-1:0] ONE_IDX = IW'(1);

  // captured request
  logic        [ldq_pkg::MODE_W-1:0] mode_q;
  logic signed [ldq_pkg::DATA_W-1:0] value_q;

  // control state
  logic [IW-1:0] front_idx_q, front_idx_d;
  logic [IW-1:0] rear_idx_q, rear_idx_d;
  logic          out_valid_q, out_valid_d;

  // payload state
  logic signed [ldq_pkg::DATA_W-1:0]   front_val_q, front_val_d;
  logic signed [ldq_pkg::DATA_W-1:0]   rear_val_q, rear_val_d;
  logic        [ldq_pkg::STATUS_W-1:0] st_q, st_d;
  logic signed [ldq_pkg::DATA_W-1:0]   removed_q, removed_d;
  logic                                refill_front_q, refill_front_d;
  logic                                refill_rear_q, refill_rear_d;

  // element store
  logic signed [ldq_pkg::DATA_W-1:0] mem [CAPACITY];
  logic signed [ldq_pkg::DATA_W-1:0] rd_data_q;
  logic                              mem_we, mem_re;
  logic        [AW-1:0]              mem_wa, mem_ra;
  logic signed [ldq_pkg::DATA_W-1:0] mem_wd;

  // execute-step helpers
  logic          cur_empty;
  logic [IW-1:0] front_inc, rear_dec, rear_dec2, front_dec;

  // finish-step helpers
  logic                              post_empty;
  logic signed [ldq_pkg::DATA_W-1:0] new_front_val, new_rear_val;
  logic        [CW-1:0]              count_ext;

  assign cur_empty = (front_idx_q >= rear_idx_q);
  assign front_inc = front_idx_q + ONE_IDX;
  assign front_dec = front_idx_q - ONE_IDX;
  assign rear_dec  = rear_idx_q - ONE_IDX;
  assign rear_dec2 = rear_dec - ONE_IDX;

  always_comb begin
    front_idx_d    = front_idx_q;
    rear_idx_d     = rear_idx_q;
    front_val_d    = front_val_q;
    rear_val_d     = rear_val_q;
    st_d           = st_q;
    removed_d      = removed_q;
    refill_front_d = refill_front_q;
    refill_rear_d  = refill_rear_q;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = value_q;
    mem_re         = 1'b0;
    mem_ra         = '0;

    if (cmd_i.exec) begin
      st_d           = ldq_pkg::ST_DONE;
      removed_d      = '0;
      refill_front_d = 1'b0;
      refill_rear_d  = 1'b0;
      case (mode_q)
        ldq_pkg::MODE_PUSH_REAR: begin
          if (rear_idx_q == CAP_IDX) begin
            st_d = ldq_pkg::ST_OVERFLOW;
          end else begin
            mem_we     = 1'b1;
            mem_wa     = rear_idx_q[AW-1:0];
            rear_idx_d = rear_idx_q + ONE_IDX;
            rear_val_d = value_q;
            if (cur_empty) begin
              front_val_d = value_q;
            end
          end
        end
        ldq_pkg::MODE_PUSH_FRONT: begin
          if (front_idx_q == '0 && rear_idx_q == '0) begin
            mem_we      = 1'b1;
            mem_wa      = '0;
            rear_idx_d  = ONE_IDX;
            front_val_d = value_q;
            rear_val_d  = value_q;
          end else if (front_idx_q != '0) begin
            mem_we      = 1'b1;
            mem_wa      = front_dec[AW-1:0];
            front_idx_d = front_dec;
            front_val_d = value_q;
          end else begin
            st_d = ldq_pkg::ST_OVERFLOW;
          end
        end
        ldq_pkg::MODE_POP_FRONT: begin
          if (cur_empty) begin
            st_d = ldq_pkg::ST_EMPTY;
          end else begin
            removed_d = front_val_q;
            if (front_inc >= rear_idx_q) begin
              front_idx_d = '0;
              rear_idx_d  = '0;
            end else begin
              front_idx_d    = front_inc;
              mem_re         = 1'b1;
              mem_ra         = front_inc[AW-1:0];
              refill_front_d = 1'b1;
            end
          end
        end
        default: begin  // pop at rear
          if (cur_empty) begin
            st_d = ldq_pkg::ST_EMPTY;
          end else begin
            removed_d = rear_val_q;
            if (front_idx_q >= rear_dec) begin
              front_idx_d = '0;
              rear_idx_d  = '0;
            end else begin
              rear_idx_d    = rear_dec;
              mem_re        = 1'b1;
              mem_ra        = rear_dec2[AW-1:0];
              refill_rear_d = 1'b1;
            end
          end
        end
      endcase
    end else if (cmd_i.finish) begin
      front_val_d = new_front_val;
      rear_val_d  = new_rear_val;
    end
  end

  // results after the operation
  assign post_empty    = (front_idx_q >= rear_idx_q);
  assign new_front_val = refill_front_q ? rd_data_q : front_val_q;
  assign new_rear_val  = refill_rear_q ? rd_data_q : rear_val_q;
  assign count_ext     = CW'(rear_idx_q) - CW'(front_idx_q);

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx_q <= '0;
      rear_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_idx_q <= front_idx_d;
      rear_idx_q  <= rear_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      value_q <= item_value_i;
    end
    front_val_q    <= front_val_d;
    rear_val_q     <= rear_val_d;
    st_q           <= st_d;
    removed_q      <= removed_d;
    refill_front_q <= refill_front_d;
    refill_rear_q  <= refill_rear_d;
    if (cmd_i.finish) begin
      result_status_o <= st_q;
      removed_value_o <= removed_q;
      is_empty_o      <= post_empty;
      front_value_o   <= post_empty ? '0 : new_front_val;
      rear_value_o    <= post_empty ? '0 : new_rear_val;
      item_count_o    <= post_empty ? '0 : count_ext[ldq_pkg::COUNT_W-1:0];
    end
  end

  // store: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_ra];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/linear_array_deque_top.sv =====
// Linear array deque top level. An accepted item passes through execute (store
// write/read) and then finish (into the result register) before its result is
// valid; the next item is accepted only after finish, the finish step folding in
// the store read that refills a cached end value after a pop; finish stalls while
// an unclaimed result holds the output. Reset (rst_ni low, asynchronous) empties
// the deque and clears the result channel; store contents stay undefined.
// Depends on ldq_pkg, ldq_in_if, ldq_out_if, ldq_ctrl and ldq_dp.
`default_nettype none

module linear_array_deque_top #(
  parameter int unsigned CAPACITY = ldq_pkg::CAPACITY_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ldq_in_if.sink    in_i,
  ldq_out_if.source out_o
);

  ldq_pkg::ctrl_cmd_t  cmd;
  ldq_pkg::dp_status_t dp_status;

  // Controller: walks each item through capture -> execute -> finish.
  // A new item is taken in the idle state even while the previous result
  // still sits unclaimed in the output register; finish waits for it.
  ldq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  // Datapath: front/rear indices, the element store, cached copies of the
  // front and rear elements (so pushes and pop results need no read), and
  // the result register that drives the output channel.
  ldq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .mode_i          (in_i.mode),
    .item_value_i    (in_i.item_value),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .result_status_o (out_o.status),
    .removed_value_o (out_o.removed_value),
    .front_value_o   (out_o.front_value),
    .rear_value_o    (out_o.rear_value),
    .is_empty_o      (out_o.is_empty),
    .item_count_o    (out_o.item_count)
  );

endmodule

`default_nettype wire

// ===== verif/ldq_checker.sv =====
// Result checker for the linear array deque: tracks the deque contents from the accepted
// requests, predicts each result and compares it with what the block returns.
// Depends on ldq_pkg and the ldq_in_if / ldq_out_if channels.
`default_nettype none

module ldq_checker #(
  parameter int unsigned CAPACITY = ldq_pkg::CAPACITY_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ldq_in_if          mon_in_i,
  ldq_out_if         mon_out_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [ldq_pkg::STATUS_W-1:0]      status;
    logic signed [ldq_pkg::DATA_W-1:0] removed;
    logic signed [ldq_pkg::DATA_W-1:0] front_v;
    logic signed [ldq_pkg::DATA_W-1:0] rear_v;
    logic                              empty;
    logic [ldq_pkg::COUNT_W-1:0]       count;
  } deque_result_t;

  logic signed [ldq_pkg::DATA_W-1:0] slots [CAPACITY];
  int unsigned                       head_idx;
  int unsigned                       tail_idx;
  deque_result_t                     want_q [$];

  // one operation on the tracked deque, held positions are head_idx .. tail_idx-1
  function automatic deque_result_t apply_op(input logic [ldq_pkg::MODE_W-1:0] op,
                                             input logic signed [ldq_pkg::DATA_W-1:0] val);
    deque_result_t r;
    r        = '0;
    r.status = ldq_pkg::ST_DONE;
    case (op)
      ldq_pkg::MODE_PUSH_REAR: begin
        if (tail_idx >= CAPACITY) begin
          r.status = ldq_pkg::ST_OVERFLOW;
        end else begin
          slots[tail_idx] = val;
          tail_idx++;
        end
      end
      ldq_pkg::MODE_PUSH_FRONT: begin
        if (head_idx == 0 && tail_idx == 0) begin
          slots[0] = val;
          tail_idx = 1;
        end else if (head_idx != 0) begin
          head_idx--;
          slots[head_idx] = val;
        end else begin
          r.status = ldq_pkg::ST_OVERFLOW;
        end
      end
      ldq_pkg::MODE_POP_FRONT: begin
        if (head_idx >= tail_idx) begin
          r.status = ldq_pkg::ST_EMPTY;
        end else begin
          r.removed = slots[head_idx];
          head_idx++;
          if (head_idx >= tail_idx) begin
            head_idx = 0;
            tail_idx = 0;
          end
        end
      end
      ldq_pkg::MODE_POP_REAR: begin
        if (head_idx >= tail_idx) begin
          r.status = ldq_pkg::ST_EMPTY;
        end else begin
          r.removed = slots[tail_idx-1];
          tail_idx--;
          if (head_idx >= tail_idx) begin
            head_idx = 0;
            tail_idx = 0;
          end
        end
      end
    endcase
    if (head_idx >= tail_idx) begin
      r.empty = 1'b1;
    end else begin
      r.front_v = slots[head_idx];
      r.rear_v  = slots[tail_idx-1];
      r.count   = ldq_pkg::COUNT_W'(tail_idx - head_idx);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst_ni) begin
      head_idx  = 0;
      tail_idx  = 0;
      want_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (mon_out_i.valid && mon_out_i.ready) begin
        got.status  = mon_out_i.status;
        got.removed = mon_out_i.removed_value;
        got.front_v = mon_out_i.front_value;
        got.rear_v  = mon_out_i.rear_value;
        got.empty   = mon_out_i.is_empty;
        got.count   = mon_out_i.item_count;
        if (want_q.size() == 0) begin
          if (err_cnt_o < 10)
            $display("ldq_checker: unexpected result st=%0d rm=%h fr=%h rr=%h e=%0d n=%0d",
                     got.status, got.removed, got.front_v, got.rear_v, got.empty, got.count);
          err_cnt_o++;
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            if (err_cnt_o < 10) begin
              $display("ldq_checker: mismatch exp st=%0d rm=%h fr=%h rr=%h e=%0d n=%0d",
                       want.status, want.removed, want.front_v, want.rear_v, want.empty,
                       want.count);
              $display("ldq_checker:          got st=%0d rm=%h fr=%h rr=%h e=%0d n=%0d",
                       got.status, got.removed, got.front_v, got.rear_v, got.empty,
                       got.count);
            end
            err_cnt_o++;
          end
        end
      end
      if (mon_in_i.valid && mon_in_i.ready)
        want_q.push_back(apply_op(mon_in_i.mode, mon_in_i.item_value));
      pending_o = want_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== verif/linear_array_deque_top_tb.sv =====
// Testbench top for the linear array deque: clock, reset, request stimulus and result-side
// backpressure; checking is done by ldq_checker, the verdict here.
// Depends on ldq_pkg, ldq_if, linear_array_deque_top and ldq_checker.
`default_nettype none

module linear_array_deque_top_tb;

  localparam int unsigned IDLE_LIMIT = 5000;  // cycles with no item moving on either side

  // operation mixes for the random part; each favors a different corner of the deque
  typedef enum logic [1:0] {
    MIX_FILL,   // mostly rear pushes, runs into the full/overflow case
    MIX_CHURN,  // front pops and front pushes, reuses freed front slots
    MIX_DRAIN,  // mostly pops, empties the deque and hits the empty status
    MIX_FLAT    // all four operations alike
  } op_mix_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        calm;           // high: neither side idles
  int unsigned err_cnt;
  int unsigned pending_cnt;
  int unsigned quiet_cycles = 0;

  ldq_in_if  in_ch ();
  ldq_out_if out_ch ();

  always #4 clk_i = ~clk_i;

  linear_array_deque_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  ldq_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mon_in_i  (in_ch),
    .mon_out_i (out_ch),
    .err_cnt_o (err_cnt),
    .pending_o (pending_cnt)
  );

  // Result side: drop ready at random, about 22 times in 100, unless in a calm stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  // Watchdog. Sampled at the falling edge, so it sees what the next rising edge accepts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("linear_array_deque_top_tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one request and hold it until taken. Called at a rising edge; returns at one.
  // ready is looked at on the falling edge, away from the edge where the block updates it.
  task automatic send_op(input logic [ldq_pkg::MODE_W-1:0] op,
                         input logic signed [ldq_pkg::DATA_W-1:0] val);
    bit took;
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= op;
    in_ch.item_value <= val;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
    // now and then a random gap with valid low, outside calm stretches
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [ldq_pkg::MODE_W-1:0] pick_op(input op_mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:
        return (r < 60) ? ldq_pkg::MODE_PUSH_REAR : (r < 75) ? ldq_pkg::MODE_PUSH_FRONT :
               (r < 90) ? ldq_pkg::MODE_POP_FRONT : ldq_pkg::MODE_POP_REAR;
      MIX_CHURN:
        return (r < 40) ? ldq_pkg::MODE_PUSH_FRONT : (r < 80) ? ldq_pkg::MODE_POP_FRONT :
               (r < 90) ? ldq_pkg::MODE_PUSH_REAR : ldq_pkg::MODE_POP_REAR;
      MIX_DRAIN:
        return (r < 35) ? ldq_pkg::MODE_POP_FRONT : (r < 70) ? ldq_pkg::MODE_POP_REAR :
               (r < 90) ? ldq_pkg::MODE_PUSH_REAR : ldq_pkg::MODE_PUSH_FRONT;
      default:
        return (r < 25) ? ldq_pkg::MODE_PUSH_REAR : (r < 50) ? ldq_pkg::MODE_PUSH_FRONT :
               (r < 75) ? ldq_pkg::MODE_POP_FRONT : ldq_pkg::MODE_POP_REAR;
    endcase
  endfunction

  // mostly full-range random, now and then one of the corner values
  function automatic logic signed [ldq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    op_mix_e mix;
    int      mix_left;
    mix              = MIX_FLAT;
    mix_left         = 0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= ldq_pkg::MODE_PUSH_REAR;
    in_ch.item_value <= '0;
    calm             <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    send_op(ldq_pkg::MODE_POP_FRONT, 32'sd5);           // pop front of an empty deque
    send_op(ldq_pkg::MODE_POP_REAR, 32'sd6);            // pop rear of an empty deque
    send_op(ldq_pkg::MODE_PUSH_FRONT, 32'sh7fff_ffff);  // push front with both indices at zero
    send_op(ldq_pkg::MODE_PUSH_FRONT, 32'sd1);          // front index zero, not empty: overflow
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'sh8000_0000);
    send_op(ldq_pkg::MODE_POP_REAR, '0);
    send_op(ldq_pkg::MODE_POP_REAR, '0);                // empties, indices back to zero
    send_op(ldq_pkg::MODE_PUSH_REAR, '1);
    send_op(ldq_pkg::MODE_PUSH_REAR, '0);
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'sh5555_5555);
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'shaaaa_aaaa);
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'sd1);
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'sd2);
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'sd3);
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'sd4);           // rear index now at capacity
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'sd9);           // full: overflow
    send_op(ldq_pkg::MODE_POP_FRONT, '0);
    send_op(ldq_pkg::MODE_POP_FRONT, '0);
    send_op(ldq_pkg::MODE_PUSH_FRONT, 32'sh1234_5678);  // reuses a freed front slot
    send_op(ldq_pkg::MODE_PUSH_REAR, 32'sd10);          // still full at the rear: overflow
    for (int k = 0; k < 7; k++)                         // drain to empty from both ends
      send_op((k % 2) ? ldq_pkg::MODE_POP_REAR : ldq_pkg::MODE_POP_FRONT, '0);
    wait_drained();

    // Random part: runs of one operation mix, a calm stretch and one full drain midway.
    for (int n = 0; n < 1900; n++) begin
      if (n == 700)
        calm <= 1'b1;
      if (n == 1000)
        calm <= 1'b0;
      if (n == 1200)
        wait_drained();
      if (mix_left == 0) begin
        mix      = op_mix_e'($urandom_range(0, 3));
        mix_left = $urandom_range(8, 24);
      end
      send_op(pick_op(mix), pick_value());
      mix_left--;
    end
    in_ch.valid <= 1'b0;

    // Wait for the last results, then idle on to catch any stray output.
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("linear_array_deque_top_tb: done, clean");
    end else begin
      $display("linear_array_deque_top_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
